[hdl/lpg_pkg.sv]
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DIM_BITS   = 13;
  localparam int SPAN_BITS  = 12;
  localparam int DELTA_BITS = 13;
  localparam int ERR_BITS   = 16;
  localparam int INDEX_BITS = 24;
  localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int PROD_BITS  = 2 * DIM_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN_LIMIT   = 2'd2;

  localparam logic [DIM_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [SPAN_BITS-1:0] SPAN_LIMIT_RESET   = 12'd1000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } item_t;

  typedef struct packed {
    coord_t                  pix_x;
    coord_t                  pix_y;
    logic                    in_frame;
    logic [INDEX_BITS-1:0]   pixel_index;
    logic                    last;
  } pixel_t;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_DROP    = 2'd2
  } cmd_kind_t;

  // One classified transaction, as it waits between the front and back ends.
  typedef struct packed {
    cmd_kind_t               kind;
    logic                    steep;
    logic                    minor_neg;
    logic [DELTA_BITS-1:0]   delta_major;
    logic [DELTA_BITS-1:0]   delta_minor;
    coord_t                  a_major;
    coord_t                  a_minor;
    coord_t                  b_major;
  } cmd_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } frame_t;

endpackage

[hdl/lpg_front.sv]
`timescale 1ns / 1ps

module lpg_front (
  input  lpg_pkg::item_t                  item,
  input  logic [lpg_pkg::SPAN_BITS-1:0]   span_limit,
  output lpg_pkg::cmd_t                   cmd
);
  import lpg_pkg::*;

  logic signed [DIFF_BITS-1:0] dx, dy, ndx, ndy;
  logic [DIFF_BITS-1:0]        adx, ady;
  logic                        drop, steep, swap;

  // Both signs of each difference are formed side by side, so the magnitude is a select.
  assign dx  = DIFF_BITS'(item.end_x) - DIFF_BITS'(item.start_x);
  assign dy  = DIFF_BITS'(item.end_y) - DIFF_BITS'(item.start_y);
  assign ndx = DIFF_BITS'(item.start_x) - DIFF_BITS'(item.end_x);
  assign ndy = DIFF_BITS'(item.start_y) - DIFF_BITS'(item.end_y);
  assign adx = dx[DIFF_BITS-1] ? ndx : dx;
  assign ady = dy[DIFF_BITS-1] ? ndy : dy;

  assign drop  = (adx > DIFF_BITS'(span_limit)) || (ady > DIFF_BITS'(span_limit));
  assign steep = !(ady < adx);
  assign swap  = steep ? dy[DIFF_BITS-1] : dx[DIFF_BITS-1];

  always_comb begin
    if (item.action == ACT_ADVANCE) begin
      cmd.kind = CMD_ADVANCE;
    end else if (drop) begin
      cmd.kind = CMD_DROP;
    end else begin
      cmd.kind = CMD_LOAD;
    end
    cmd.steep = steep;
    // The minor step is negative when the minor difference, seen from the lower end, is.
    if (steep) begin
      cmd.minor_neg   = (dx != '0) && (dx[DIFF_BITS-1] ^ dy[DIFF_BITS-1]);
      cmd.delta_major = DELTA_BITS'(ady);
      cmd.delta_minor = DELTA_BITS'(adx);
      cmd.a_major     = swap ? item.end_y : item.start_y;
      cmd.a_minor     = swap ? item.end_x : item.start_x;
      cmd.b_major     = swap ? item.start_y : item.end_y;
    end else begin
      cmd.minor_neg   = (dy != '0) && (dy[DIFF_BITS-1] ^ dx[DIFF_BITS-1]);
      cmd.delta_major = DELTA_BITS'(adx);
      cmd.delta_minor = DELTA_BITS'(ady);
      cmd.a_major     = swap ? item.end_x : item.start_x;
      cmd.a_minor     = swap ? item.end_y : item.start_y;
      cmd.b_major     = swap ? item.start_x : item.end_x;
    end
  end

endmodule

[hdl/lpg_queue.sv]
`timescale 1ns / 1ps

module lpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lpg_pkg::cmd_t  push_data,
  input  logic           pop,
  output lpg_pkg::cmd_t  pop_data,
  output logic           full,
  output logic           empty
);
  import lpg_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[hdl/lpg_back.sv]
`timescale 1ns / 1ps

module lpg_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  lpg_pkg::cmd_t   cmd,
  output logic            pop,
  input  lpg_pkg::frame_t frame,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output lpg_pkg::pixel_t pixel
);
  import lpg_pkg::*;

  // Line state
  logic                       busy;
  logic                       steep;
  coord_t                     cur_major, cur_minor, end_major;
  logic                       minor_neg;
  logic signed [ERR_BITS-1:0] error_term, inc_straight, inc_diag;

  // Pixel stage
  logic                       p_valid;
  coord_t                     p_x, p_y;
  logic                       p_inside, p_last;

  logic                       o_en, p_en, emit, fin, err_pos, in_win;
  coord_t                     px, py;
  logic [DIM_BITS-1:0]        px_d, py_d;
  logic [PROD_BITS-1:0]       prod;
  logic [INDEX_BITS-1:0]      idx;

  assign o_en = !pixel_valid || !pixel_stall;
  assign p_en = !p_valid || o_en;
  assign pop  = cmd_valid && p_en;
  assign emit = pop && (cmd.kind == CMD_ADVANCE) && busy;

  assign px      = steep ? cur_minor : cur_major;
  assign py      = steep ? cur_major : cur_minor;
  assign fin     = (cur_major >= end_major);
  assign err_pos = !error_term[ERR_BITS-1] && (error_term != '0);
  assign in_win  = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                   (CMP_BITS'($unsigned(px)) < CMP_BITS'(frame.width)) &&
                   (CMP_BITS'($unsigned(py)) < CMP_BITS'(frame.height));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      unique case (cmd.kind)
        CMD_LOAD:    busy <= 1'b1;
        CMD_DROP:    busy <= 1'b0;
        CMD_ADVANCE: if (busy && fin) busy <= 1'b0;
        default:     busy <= 1'b0;
      endcase
    end
  end

  // Both error increments are fixed for the whole line, so they are formed once at load.
  always_ff @(posedge clk) begin
    if (pop && (cmd.kind == CMD_LOAD)) begin
      steep        <= cmd.steep;
      minor_neg    <= cmd.minor_neg;
      cur_major    <= cmd.a_major;
      cur_minor    <= cmd.a_minor;
      end_major    <= cmd.b_major;
      error_term   <= ERR_BITS'({cmd.delta_minor, 1'b0}) - ERR_BITS'(cmd.delta_major);
      inc_straight <= ERR_BITS'({cmd.delta_minor, 1'b0});
      inc_diag     <= ERR_BITS'({cmd.delta_minor, 1'b0}) - ERR_BITS'({cmd.delta_major, 1'b0});
    end else if (emit) begin
      if (err_pos) begin
        cur_minor  <= minor_neg ? cur_minor - coord_t'(1) : cur_minor + coord_t'(1);
        error_term <= error_term + inc_diag;
      end else begin
        error_term <= error_term + inc_straight;
      end
      if (!fin) begin
        cur_major <= cur_major + coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_en) begin
      p_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (p_en) begin
      p_x      <= px;
      p_y      <= py;
      p_inside <= in_win;
      p_last   <= fin;
    end
  end

  // Inside the frame both coordinates are below 2^13, so the narrow operands are exact.
  assign px_d = DIM_BITS'($unsigned(p_x));
  assign py_d = DIM_BITS'($unsigned(p_y));
  assign prod = py_d * frame.width;
  assign idx  = INDEX_BITS'(prod) + INDEX_BITS'(px_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (o_en) begin
      pixel_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en) begin
      pixel.pix_x       <= p_x;
      pixel.pix_y       <= p_y;
      pixel.in_frame    <= p_inside;
      pixel.pixel_index <= p_inside ? idx : '0;
      pixel.last        <= p_last;
    end
  end

endmodule

[hdl/line_pixel_generator.sv]
`timescale 1ns / 1ps

// Bresenham line engine for all octants. A load transaction carries two endpoints; a
// line whose span on either axis exceeds span_limit is dropped and leaves the engine idle.
// Each advance transaction on an active line yields one pixel with its coordinates, an
// in-frame flag, the linear index row * frame_width + column (zero outside the frame) and
// a last flag; advances on an idle engine yield nothing. One transaction is taken every
// clock unless the queue is full: the front end classifies loads in the same cycle, a
// two-entry queue separates it from the stepping back end, and the step itself is one
// add and compare per clock. A pixel leaves through the pixel stage and output registers,
// the multiply-add that forms the index between them. Configuration may only be written while idle.
module line_pixel_generator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  lpg_pkg::item_t                       item,
  output logic                                 pixel_valid,
  input  logic                                 pixel_stall,
  output lpg_pkg::pixel_t                      pixel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [lpg_pkg::DIM_BITS-1:0]         cfg_data
);
  import lpg_pkg::*;

  logic [DIM_BITS-1:0]  frame_width, frame_height;
  logic [SPAN_BITS-1:0] span_limit;
  frame_t               frame;
  cmd_t                 front_cmd, back_cmd;
  logic                 q_full, q_empty, q_pop;

  assign cfg_ready    = 1'b1;
  assign item_stall   = q_full;
  assign frame.width  = frame_width;
  assign frame.height = frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
      span_limit   <= SPAN_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_SPAN_LIMIT:   span_limit   <= cfg_data[SPAN_BITS-1:0];
        default:          ;
      endcase
    end
  end

  lpg_front u_front (
    .item       (item),
    .span_limit (span_limit),
    .cmd        (front_cmd)
  );

  lpg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && !q_full),
    .push_data (front_cmd),
    .pop       (q_pop),
    .pop_data  (back_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  lpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!q_empty),
    .cmd         (back_cmd),
    .pop         (q_pop),
    .frame       (frame),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

  a_no_pixel_after_reset: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel offered straight after reset");

  a_index_zero_outside: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel.in_frame |-> pixel.pixel_index == '0)
    else $error("pixel outside the frame carries a non-zero index");

  a_in_frame_bounds: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.in_frame |->
      !pixel.pix_x[COORD_BITS-1] && !pixel.pix_y[COORD_BITS-1] &&
      (CMP_BITS'($unsigned(pixel.pix_x)) < CMP_BITS'(frame_width)) &&
      (CMP_BITS'($unsigned(pixel.pix_y)) < CMP_BITS'(frame_height)))
    else $error("pixel flagged in frame lies outside it");

  a_queue_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end took a transaction from an empty queue");

endmodule
